// ----- sv/bdxf_pkg.sv -----
package bdxf_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [15:0] group_code;
    logic [2:0]  value_kind;
    logic [63:0] payload;
    logic        is_char;
    logic        last;
    logic [2:0]  error;
  } out_item_t;

  localparam logic [2:0] K_STR = 3'd0;
  localparam logic [2:0] K_DBL = 3'd1;
  localparam logic [2:0] K_I16 = 3'd2;
  localparam logic [2:0] K_I32 = 3'd3;
  localparam logic [2:0] K_I64 = 3'd4;
  localparam logic [2:0] K_BLN = 3'd5;
  localparam logic [2:0] K_BIN = 3'd6;
  localparam logic [2:0] K_UNK = 3'd7;

  localparam logic [2:0] E_NONE  = 3'd0;
  localparam logic [2:0] E_CHUNK = 3'd1;
  localparam logic [2:0] E_NAN   = 3'd2;
  localparam logic [2:0] E_HDL   = 3'd3;
  localparam logic [2:0] E_UNK   = 3'd4;
  localparam logic [2:0] E_TRUNC = 3'd5;

  localparam logic [1:0] CFG_SHORT = 2'd0;
  localparam logic [1:0] CFG_IGN   = 2'd1;
  localparam logic [1:0] CFG_SKIP  = 2'd2;
  localparam logic [1:0] CFG_WIDE  = 2'd3;

  localparam logic [15:0] CODE_COMMENT = 16'd999;

  // range table for group codes
  function automatic logic [2:0] kind_of(input logic [15:0] c);
    logic [2:0] k;
    if (c <= 16'd9) k = K_STR;
    else if (c <= 16'd59) k = K_DBL;
    else if (c <= 16'd79) k = K_I16;
    else if (c <= 16'd89) k = K_STR;
    else if (c <= 16'd99) k = K_I32;
    else if (c <= 16'd109) k = K_STR;
    else if (c <= 16'd149) k = K_DBL;
    else if (c <= 16'd159) k = K_STR;
    else if (c <= 16'd169) k = K_I64;
    else if (c <= 16'd179) k = K_I16;
    else if (c <= 16'd209) k = K_STR;
    else if (c <= 16'd259) k = K_DBL;
    else if (c <= 16'd269) k = K_BLN;
    else if (c <= 16'd289) k = K_I16;
    else if (c <= 16'd299) k = K_BLN;
    else if (c <= 16'd309) k = K_STR;
    else if (c <= 16'd319) k = K_BIN;
    else if (c <= 16'd369) k = K_STR;
    else if (c <= 16'd389) k = K_I16;
    else if (c <= 16'd399) k = K_STR;
    else if (c <= 16'd409) k = K_I16;
    else if (c <= 16'd419) k = K_STR;
    else if (c <= 16'd429) k = K_I32;
    else if (c <= 16'd439) k = K_STR;
    else if (c <= 16'd459) k = K_I32;
    else if (c <= 16'd469) k = K_DBL;
    else if (c <= 16'd481) k = K_STR;
    else if (c == 16'd1004) k = K_BIN;
    else if (c <= 16'd998) k = K_DBL;
    else if (c <= 16'd1008) k = K_STR;
    else if (c <= 16'd1059) k = K_DBL;
    else if (c <= 16'd1070) k = K_I16;
    else if (c == 16'd1071) k = K_I32;
    else k = K_UNK;
    return k;
  endfunction

  function automatic logic is_handle_code(input logic [15:0] c);
    return c == 16'd105 || c == 16'd1005 || (c >= 16'd320 && c <= 16'd369) ||
           (c >= 16'd390 && c <= 16'd399) || c == 16'd480 || c == 16'd481;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

endpackage

// ----- sv/bdxf_out_queue.sv -----
module bdxf_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_cnt,
  input  bdxf_pkg::out_item_t push0,
  input  bdxf_pkg::out_item_t push1,
  output logic                room2,
  output logic                out_valid,
  input  logic                out_ready,
  output bdxf_pkg::out_item_t out_data
);
  import bdxf_pkg::*;

  // four-entry fifo holding up to two results per transfer
  out_item_t   mem_r [4];
  logic [1:0]  rd_r, wr_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = mem_r[rd_r];
  assign room2     = (cnt_r - {2'd0, pop}) <= 3'd2;
  assign cnt_nxt   = cnt_r + {1'b0, push_cnt} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 2'd0;
      wr_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r  <= wr_r + push_cnt;
      if (pop) rd_r <= rd_r + 2'd1;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wr_r + 2'd1] <= push1;
  end
endmodule

// ----- sv/binary_dxf_group_parser.sv -----
// Binary DXF group parser.
// in_ channel: one stream byte per transfer (in_data.data_byte), or an
// end-of-stream marker (in_data.end_of_stream). Each transfer yields zero,
// one or two results on the out_ channel: string characters, hex pairs of
// binary chunks, whole numeric values, or one error result.
// cfg_ port: cfg_we with cfg_index and cfg_wdata[0] sets short codes,
// comment dropping, unknown-code skipping and wide handles. Write only
// while the block is idle.
// A result is registered in the output queue before it is offered.
// Throughput: one byte per cycle while the queue has room for two results,
// set by the single decode step between the input and the four-entry
// output queue; a byte giving two results is taken whenever the queue has
// two free places, so a long run of chunk data waits on the queue draining.
// Reset (rst_n low, synchronous) returns to waiting for a group code,
// clears the configuration and empties the queue.
// When the receiver stalls the queue fills and in_ready falls; nothing is
// lost. After an error the block swallows all input until reset.
module binary_dxf_group_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdxf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bdxf_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [0:0]          cfg_wdata
);
  import bdxf_pkg::*;

  localparam logic [2:0] PH_CODE = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_STR  = 3'd2;
  localparam logic [2:0] PH_BLEN = 3'd3;
  localparam logic [2:0] PH_BDAT = 3'd4;
  localparam logic [2:0] PH_NUM  = 3'd5;

  logic short_r, ign_r, skip_r, wide_r;
  logic [2:0] ph_r, ph_nxt;
  logic [3:0] bc_r, bc_nxt;
  logic [15:0] code_r, code_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [63:0] val_r, val_nxt;
  logic [6:0] rem_r, rem_nxt;
  logic [4:0] hlen_r, hlen_nxt, sig_r, sig_nxt;
  logic hok_r, hok_nxt, drop_r, drop_nxt, halt_r, halt_nxt;

  logic [1:0] push_cnt;
  out_item_t push0, push1;
  logic room2, take;
  logic [7:0] b;
  logic [15:0] c;
  logic [2:0] k;
  logic [63:0] v;
  logic [3:0] need;
  logic dig, hvalid;

  assign in_ready = room2;
  assign take = in_valid && in_ready;
  assign b = in_data.data_byte;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= 1'b0;
      ign_r   <= 1'b0;
      skip_r  <= 1'b0;
      wide_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT: short_r <= cfg_wdata[0];
        CFG_IGN:   ign_r   <= cfg_wdata[0];
        CFG_SKIP:  skip_r  <= cfg_wdata[0];
        CFG_WIDE:  wide_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // per-byte decode
  always_comb begin
    ph_nxt = ph_r; bc_nxt = bc_r; code_nxt = code_r; kind_nxt = kind_r;
    val_nxt = val_r; rem_nxt = rem_r; hlen_nxt = hlen_r; sig_nxt = sig_r;
    hok_nxt = hok_r; drop_nxt = drop_r; halt_nxt = halt_r;
    push_cnt = 2'd0;
    push0 = '{group_code: code_r, value_kind: kind_r, payload: 64'd0,
              is_char: 1'b0, last: 1'b1, error: E_NONE};
    push1 = push0;
    c = code_r;
    k = K_STR;
    v = val_r;
    need = 4'd8;
    dig = 1'b0;
    hvalid = 1'b0;
    if (take && !halt_r) begin
      if (in_data.end_of_stream) begin
        if (!(ph_r == PH_CODE && bc_r == 4'd0)) begin
          push_cnt = 2'd1;
          halt_nxt = 1'b1;
          push0.error = E_TRUNC;
          if (ph_r == PH_CODE || ph_r == PH_ESC) push0.value_kind = K_STR;
        end
      end else begin
        unique case (ph_r)
          PH_CODE, PH_ESC: begin
            if (ph_r == PH_CODE && short_r && b == 8'hFF) begin
              code_nxt = 16'd0;
              bc_nxt = 4'd0;
              ph_nxt = PH_ESC;
            end else if (ph_r == PH_CODE && short_r) begin
              c = {8'd0, b};
            end else if (bc_r == 4'd0) begin
              code_nxt = {8'd0, b};
              bc_nxt = 4'd1;
            end else begin
              c = {b, code_r[7:0]};
            end
            // code complete
            if (!(ph_r == PH_CODE && short_r && b == 8'hFF) &&
                !(!(ph_r == PH_CODE && short_r) && bc_r == 4'd0)) begin
              code_nxt = c;
              k = kind_of(c);
              bc_nxt = 4'd0; val_nxt = 64'd0; drop_nxt = 1'b0;
              hlen_nxt = 5'd0; sig_nxt = 5'd0; hok_nxt = 1'b1;
              if (c == CODE_COMMENT && ign_r) begin
                drop_nxt = 1'b1;
                kind_nxt = K_STR;
                ph_nxt = PH_STR;
              end else if (k == K_UNK && !skip_r) begin
                kind_nxt = K_STR;
                halt_nxt = 1'b1;
                push_cnt = 2'd1;
                push0.group_code = c;
                push0.value_kind = K_STR;
                push0.error = E_UNK;
              end else begin
                if (k == K_UNK) k = K_STR;
                kind_nxt = k;
                if (k == K_STR) ph_nxt = PH_STR;
                else if (k == K_BIN) ph_nxt = PH_BLEN;
                else ph_nxt = PH_NUM;
              end
            end
          end
          PH_STR: begin
            if (b == 8'd0) begin
              hvalid = hok_r && hlen_r != 5'd0 &&
                       (wide_r ? hlen_r <= 5'd16 : sig_r <= 5'd8);
              ph_nxt = PH_CODE; bc_nxt = 4'd0; drop_nxt = 1'b0;
              if (!drop_r) begin
                push_cnt = 2'd1;
                push0.value_kind = K_STR;
                if (is_handle_code(code_r) && !hvalid) begin
                  push0.error = E_HDL;
                  halt_nxt = 1'b1;
                end
              end
            end else begin
              dig = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
                    (b >= 8'h41 && b <= 8'h46);
              if (!dig) hok_nxt = 1'b0;
              else begin
                if (hlen_r < 5'd31) hlen_nxt = hlen_r + 5'd1;
                if ((sig_r != 5'd0 || b != 8'h30) && sig_r < 5'd31)
                  sig_nxt = sig_r + 5'd1;
              end
              if (!drop_r) begin
                push_cnt = 2'd1;
                push0.value_kind = K_STR;
                push0.payload = {56'd0, b};
                push0.is_char = 1'b1;
                push0.last = 1'b0;
              end
            end
          end
          PH_BLEN: begin
            push0.value_kind = K_BIN;
            if (b > 8'd127) begin
              push_cnt = 2'd1;
              push0.error = E_CHUNK;
              halt_nxt = 1'b1;
            end else if (b == 8'd0) begin
              ph_nxt = PH_CODE; bc_nxt = 4'd0;
              push_cnt = 2'd1;
            end else begin
              rem_nxt = b[6:0];
              ph_nxt = PH_BDAT;
            end
          end
          PH_BDAT: begin
            rem_nxt = rem_r - 7'd1;
            push_cnt = 2'd2;
            push0.value_kind = K_BIN;
            push0.payload = {56'd0, hex_char(b[7:4])};
            push0.is_char = 1'b1;
            push0.last = 1'b0;
            push1.value_kind = K_BIN;
            push1.payload = {56'd0, hex_char(b[3:0])};
            push1.is_char = 1'b1;
            push1.last = rem_nxt == 7'd0;
            if (rem_nxt == 7'd0) begin
              ph_nxt = PH_CODE; bc_nxt = 4'd0;
            end
          end
          PH_NUM: begin
            unique case (kind_r)
              K_I16: need = 4'd2;
              K_I32: need = 4'd4;
              K_BLN: need = 4'd1;
              default: need = 4'd8;
            endcase
            v = val_r | ({56'd0, b} << {bc_r[2:0], 3'd0});
            val_nxt = v;
            bc_nxt = bc_r + 4'd1;
            if (bc_nxt >= need) begin
              if (kind_r == K_I16) v = {{48{v[15]}}, v[15:0]};
              else if (kind_r == K_I32) v = {{32{v[31]}}, v[31:0]};
              else if (kind_r == K_BLN) v = {56'd0, v[7:0]};
              push_cnt = 2'd1;
              if (kind_r == K_DBL && v[62:52] == 11'h7FF) begin
                push0.value_kind = K_DBL;
                push0.error = E_NAN;
                halt_nxt = 1'b1;
              end else begin
                push0.payload = v;
                ph_nxt = PH_CODE; bc_nxt = 4'd0; val_nxt = 64'd0;
              end
            end
          end
          default: begin
            ph_nxt = PH_CODE; bc_nxt = 4'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_CODE; bc_r <= 4'd0; code_r <= 16'd0; kind_r <= K_STR;
      val_r <= 64'd0; rem_r <= 7'd0; hlen_r <= 5'd0; sig_r <= 5'd0;
      hok_r <= 1'b1; drop_r <= 1'b0; halt_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; bc_r <= bc_nxt; code_r <= code_nxt; kind_r <= kind_nxt;
      val_r <= val_nxt; rem_r <= rem_nxt; hlen_r <= hlen_nxt; sig_r <= sig_nxt;
      hok_r <= hok_nxt; drop_r <= drop_nxt; halt_r <= halt_nxt;
    end
  end

  bdxf_out_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_cnt(push_cnt), .push0(push0), .push1(push1),
    .room2(room2), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
